// ----- rtl/core/lcdr_pkg.sv -----
package lcdr_pkg;

    localparam int CHAR_COUNT_DEF = 32;
    localparam int BLINK_BIT_DEF  = 9;

    localparam int POS_W     = 6;
    localparam int CODE_W    = 8;
    localparam int REQ_W     = 3;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] SPACE_CODE    = 8'h20;
    localparam logic [CODE_W-1:0] LINE1_CMD_RST = 8'h80;
    localparam logic [CODE_W-1:0] LINE2_CMD_RST = 8'hC0;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE1_CMD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE2_CMD = 2'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK        = 3'd0,
        REQ_WRITE_CHAR  = 3'd1,
        REQ_SET_BLINK   = 3'd2,
        REQ_CLR_BLINK   = 3'd3,
        REQ_CLR_ALL     = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        PH_SETUP  = 2'd0,
        PH_STROBE = 2'd1,
        PH_HOLD   = 2'd2
    } t_phase;

    typedef struct packed {
        logic              valid;
        t_req_type         req;
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] char_code;
    } t_store_req;

    typedef struct packed {
        logic [CODE_W-1:0] data;
        logic              rs;
        logic              en;
    } t_pins;

endpackage

// ----- rtl/core/lcdr_store.sv -----
module lcdr_store #(
    parameter int CHAR_COUNT = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcdr_pkg::t_store_req              i_req,
    input  logic [$clog2(CHAR_COUNT)-1:0]     i_rd_cell,
    output logic [lcdr_pkg::CODE_W-1:0]       o_rd_char,
    output logic                              o_rd_blink
);
    import lcdr_pkg::*;

    localparam int CELL_W = $clog2(CHAR_COUNT);

    logic [CODE_W-1:0]     r_chars [CHAR_COUNT];
    logic [CHAR_COUNT-1:0] r_blink;
    logic [CHAR_COUNT-1:0] n_blink;
    logic                  pos_ok;
    logic [CELL_W-1:0]     wr_cell;

    assign pos_ok  = i_req.position < POS_W'(CHAR_COUNT);
    assign wr_cell = i_req.position[CELL_W-1:0];

    always_comb begin
        n_blink = r_blink;
        if (i_req.valid) begin
            case (i_req.req)
                REQ_SET_BLINK: begin
                    if (pos_ok) begin
                        n_blink[wr_cell] = 1'b1;
                    end
                end
                REQ_CLR_BLINK: begin
                    if (pos_ok) begin
                        n_blink[wr_cell] = 1'b0;
                    end
                end
                REQ_CLR_ALL: begin
                    n_blink = '0;
                end
                default: begin
                    n_blink = r_blink;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink <= '0;
            for (int i = 0; i < CHAR_COUNT; i++) begin
                r_chars[i] <= SPACE_CODE;
            end
        end else begin
            r_blink <= n_blink;
            if (i_req.valid && i_req.req == REQ_WRITE_CHAR && pos_ok) begin
                r_chars[wr_cell] <= i_req.char_code;
            end
        end
    end

    assign o_rd_char  = r_chars[i_rd_cell];
    assign o_rd_blink = r_blink[i_rd_cell];

endmodule

// ----- rtl/core/lcdr_seq.sv -----
module lcdr_seq #(
    parameter int CHAR_COUNT = 32,
    parameter int BLINK_BIT  = 9
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_tick,
    input  logic [lcdr_pkg::CODE_W-1:0]           i_line1_cmd,
    input  logic [lcdr_pkg::CODE_W-1:0]           i_line2_cmd,
    output logic [$clog2(CHAR_COUNT)-1:0]         o_rd_cell,
    input  logic [lcdr_pkg::CODE_W-1:0]           i_rd_char,
    input  logic                                  i_rd_blink,
    output lcdr_pkg::t_pins                       o_result,
    output lcdr_pkg::t_pins                       o_pins,
    output logic [$clog2(CHAR_COUNT+2)-1:0]       o_slot,
    output lcdr_pkg::t_phase                      o_phase
);
    import lcdr_pkg::*;

    localparam int CELL_W     = $clog2(CHAR_COUNT);
    localparam int SLOT_W     = $clog2(CHAR_COUNT + 2);
    localparam int LINE2_SLOT = CHAR_COUNT / 2 + 1;
    localparam int LAST_SLOT  = CHAR_COUNT + 1;

    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  n_slot;
    t_phase             r_phase;
    t_phase             n_phase;
    logic [TIMER_W-1:0] r_timer;
    logic [TIMER_W-1:0] n_timer;
    t_pins              r_pins;
    t_pins              n_pins;
    logic               cmd_slot;
    logic [SLOT_W-1:0]  cell_raw;

    assign cmd_slot = (r_slot == '0) || (r_slot == SLOT_W'(LINE2_SLOT));

    always_comb begin
        if (r_slot > SLOT_W'(LINE2_SLOT)) begin
            cell_raw = r_slot - SLOT_W'(2);
        end else begin
            cell_raw = r_slot - SLOT_W'(1);
        end
        if (r_slot == '0 || cell_raw >= SLOT_W'(CHAR_COUNT)) begin
            o_rd_cell = '0;
        end else begin
            o_rd_cell = cell_raw[CELL_W-1:0];
        end
    end

    always_comb begin
        n_timer = r_timer + TIMER_W'(1);
        n_pins  = r_pins;
        n_slot  = r_slot;
        case (r_phase)
            PH_SETUP: begin
                if (cmd_slot) begin
                    n_pins.data = (r_slot == '0) ? i_line1_cmd : i_line2_cmd;
                    n_pins.rs   = 1'b0;
                end else begin
                    n_pins.data = (i_rd_blink && n_timer[BLINK_BIT]) ? SPACE_CODE
                                                                    : i_rd_char;
                    n_pins.rs   = 1'b1;
                end
                n_phase = PH_STROBE;
            end
            PH_STROBE: begin
                n_pins.en = 1'b1;
                n_phase   = PH_HOLD;
            end
            default: begin
                n_pins.en = 1'b0;
                if (cmd_slot) begin
                    n_pins.rs = 1'b1;
                end
                n_phase = PH_SETUP;
                if (r_slot >= SLOT_W'(LAST_SLOT)) begin
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_phase <= PH_SETUP;
            r_timer <= '0;
            r_pins  <= '0;
        end else if (i_tick) begin
            r_slot  <= n_slot;
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_pins  <= n_pins;
        end
    end

    assign o_result = i_tick ? n_pins : r_pins;
    assign o_pins   = r_pins;
    assign o_slot   = r_slot;
    assign o_phase  = r_phase;

endmodule

// ----- rtl/core/char_lcd_refresh_with_blink_unit.sv -----
// Character LCD refresh unit with per-cell blink.
// Requests arrive on i_valid/o_ready with i_req_type, i_position and
// i_char_code. A tick request advances the three-phase pin sequencer by one
// phase; the other request types write a character or change blink flags.
// Every request returns exactly one result on o_valid/i_ready: the LCD pin
// levels o_lcd_bus, o_lcd_rs and o_lcd_en after the request is applied.
// A request is handled in the cycle it is accepted and its result appears in
// the output register on the next cycle. The unit takes one request per cycle
// while the receiver takes each result.
// The output register is the only buffer between the two sides. While it
// holds a result that the receiver does not take, o_ready is low; when the
// receiver takes the result, a new request is accepted in the same cycle.
// The user must write the two command bytes through i_cfg_we, i_cfg_idx and
// i_cfg_wdata only while idle (not enforced); unknown indexes are ignored.
// Synchronous reset loads the default command bytes, fills the character
// store with spaces, clears the blink flags, the blink timer, the sequencer
// and the pins, and empties the output register. No clearing pass is needed.
module char_lcd_refresh_with_blink_unit #(
    parameter int CHAR_COUNT = lcdr_pkg::CHAR_COUNT_DEF,
    parameter int BLINK_BIT  = lcdr_pkg::BLINK_BIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lcdr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcdr_pkg::CODE_W-1:0]        i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [lcdr_pkg::REQ_W-1:0]         i_req_type,
    input  logic [lcdr_pkg::POS_W-1:0]         i_position,
    input  logic [lcdr_pkg::CODE_W-1:0]        i_char_code,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lcdr_pkg::CODE_W-1:0]        o_lcd_bus,
    output logic                               o_lcd_rs,
    output logic                               o_lcd_en
);
    import lcdr_pkg::*;

    localparam int CELL_W    = $clog2(CHAR_COUNT);
    localparam int SLOT_W    = $clog2(CHAR_COUNT + 2);
    localparam int LAST_SLOT = CHAR_COUNT + 1;

    logic [CODE_W-1:0] r_line1_cmd;
    logic [CODE_W-1:0] r_line2_cmd;
    logic              r_out_valid;
    t_pins             r_out;
    logic              accept;
    logic              tick;
    t_store_req        store_req;
    logic [CELL_W-1:0] rd_cell;
    logic [CODE_W-1:0] rd_char;
    logic              rd_blink;
    t_pins             result;
    t_pins             pins;
    logic [SLOT_W-1:0] slot;
    t_phase            phase;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign tick    = accept && (t_req_type'(i_req_type) == REQ_TICK);

    assign store_req.valid     = accept;
    assign store_req.req       = t_req_type'(i_req_type);
    assign store_req.position  = i_position;
    assign store_req.char_code = i_char_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line1_cmd <= LINE1_CMD_RST;
            r_line2_cmd <= LINE2_CMD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE1_CMD: r_line1_cmd <= i_cfg_wdata;
                CFG_LINE2_CMD: r_line2_cmd <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lcdr_store #(
        .CHAR_COUNT (CHAR_COUNT)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .i_rd_cell  (rd_cell),
        .o_rd_char  (rd_char),
        .o_rd_blink (rd_blink)
    );

    lcdr_seq #(
        .CHAR_COUNT (CHAR_COUNT),
        .BLINK_BIT  (BLINK_BIT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_line1_cmd (r_line1_cmd),
        .i_line2_cmd (r_line2_cmd),
        .o_rd_cell   (rd_cell),
        .i_rd_char   (rd_char),
        .i_rd_blink  (rd_blink),
        .o_result    (result),
        .o_pins      (pins),
        .o_slot      (slot),
        .o_phase     (phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_lcd_bus = r_out.data;
    assign o_lcd_rs  = r_out.rs;
    assign o_lcd_en  = r_out.en;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !accept)
        else $error("request accepted while the result register is stalled");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot <= SLOT_W'(LAST_SLOT))
        else $error("sequencer slot out of range");

    a_en_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pins.en |-> (phase == PH_HOLD))
        else $error("enable pin high outside the hold phase");

    a_result_tracks_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out == pins))
        else $error("result register differs from the pin state");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lcdr_pkg::*;

    localparam int CELLS      = CHAR_COUNT_DEF;
    localparam int LINE2_SLOT = CELLS / 2 + 1;
    localparam int LAST_SLOT  = CELLS + 1;
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;

    class lcd_pin_predictor;
        logic [CODE_W-1:0]  line1_cmd;
        logic [CODE_W-1:0]  line2_cmd;
        logic [CODE_W-1:0]  cells [CELLS];
        logic [CELLS-1:0]   blink_flags;
        logic [TIMER_W-1:0] blink_timer;
        logic [POS_W-1:0]   slot;
        t_phase             phase;
        t_pins              pins;
        t_pins              pending_pins [$];
        int                 errors;

        function new();
            line1_cmd = LINE1_CMD_RST;
            line2_cmd = LINE2_CMD_RST;
            foreach (cells[i]) cells[i] = SPACE_CODE;
            blink_flags = '0;
            blink_timer = '0;
            slot = '0;
            phase = PH_SETUP;
            pins = '0;
            errors = 0;
        endfunction

        function void advance_tick();
            logic              cmd_slot;
            int                cell_idx;
            logic [CODE_W-1:0] ch;
            cmd_slot = (slot == 0) || (slot == LINE2_SLOT);
            blink_timer = blink_timer + 1'b1;
            case (phase)
                PH_SETUP: begin
                    if (cmd_slot) begin
                        pins.data = (slot == 0) ? line1_cmd : line2_cmd;
                        pins.rs = 1'b0;
                    end else begin
                        cell_idx = (slot > LINE2_SLOT) ? slot - 2 : slot - 1;
                        if (cell_idx >= CELLS) begin
                            cell_idx = 0;
                        end
                        ch = cells[cell_idx];
                        if (blink_flags[cell_idx] && blink_timer[BLINK_BIT_DEF]) begin
                            ch = SPACE_CODE;
                        end
                        pins.data = ch;
                        pins.rs = 1'b1;
                    end
                    phase = PH_STROBE;
                end
                PH_STROBE: begin
                    pins.en = 1'b1;
                    phase = PH_HOLD;
                end
                default: begin
                    pins.en = 1'b0;
                    if (cmd_slot) begin
                        pins.rs = 1'b1;
                    end
                    phase = PH_SETUP;
                    slot = (slot >= LAST_SLOT) ? '0 : slot + 1'b1;
                end
            endcase
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                   logic [CODE_W-1:0] code);
            logic pos_ok;
            pos_ok = pos < CELLS;
            case (req)
                REQ_TICK:       advance_tick();
                REQ_WRITE_CHAR: if (pos_ok) cells[pos] = code;
                REQ_SET_BLINK:  if (pos_ok) blink_flags[pos] = 1'b1;
                REQ_CLR_BLINK:  if (pos_ok) blink_flags[pos] = 1'b0;
                REQ_CLR_ALL:    blink_flags = '0;
                default: ;
            endcase
            pending_pins.push_back(pins);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_pins(logic [CODE_W-1:0] data, logic rs, logic en);
            t_pins want;
            if (pending_pins.size() == 0) begin
                report_mismatch("result arrived with no request pending");
            end else begin
                want = pending_pins.pop_front();
                if (data !== want.data) begin
                    report_mismatch($sformatf("lcd_bus %h, expected %h", data, want.data));
                end
                if (rs !== want.rs) begin
                    report_mismatch($sformatf("lcd_rs %b, expected %b", rs, want.rs));
                end
                if (en !== want.en) begin
                    report_mismatch($sformatf("lcd_en %b, expected %b", en, want.en));
                end
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_LINE1_CMD;
    logic [CODE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [REQ_W-1:0]     i_req_type = REQ_TICK;
    logic [POS_W-1:0]     i_position = '0;
    logic [CODE_W-1:0]    i_char_code = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [CODE_W-1:0]    o_lcd_bus;
    logic                 o_lcd_rs;
    logic                 o_lcd_en;

    logic             rx_long_hold = 1'b0;
    lcd_pin_predictor pin_model = new();

    char_lcd_refresh_with_blink_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_lcd_bus   (o_lcd_bus),
        .o_lcd_rs    (o_lcd_rs),
        .o_lcd_en    (o_lcd_en)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            pin_model.check_pins(o_lcd_bus, o_lcd_rs, o_lcd_en);
        end
    end

    initial begin : receiver
        int   stall_left;
        int   roll;
        logic hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_long_hold && !hold_done) begin
                stall_left = 300;
                hold_done = 1'b1;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                roll = $urandom_range(0, 199);
                if (roll < 2) begin
                    stall_left = $urandom_range(20, 60);
                end else if (roll < 40) begin
                    stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    task automatic send_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                logic [CODE_W-1:0] code);
        int roll;
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_position <= pos;
        i_char_code <= code;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pin_model.note_request(req, pos, code);
        roll = $urandom_range(0, 99);
        gap = 0;
        if (roll < 3) begin
            gap = $urandom_range(15, 50);
        end else if (roll < 30) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random_requests(int count);
        int               roll;
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 58) begin
                req = REQ_TICK;
            end else if (roll < 74) begin
                req = REQ_WRITE_CHAR;
            end else if (roll < 84) begin
                req = REQ_SET_BLINK;
            end else if (roll < 92) begin
                req = REQ_CLR_BLINK;
            end else if (roll < 95) begin
                req = REQ_CLR_ALL;
            end else begin
                req = REQ_W'(REQ_FIRST_UNUSED + $urandom_range(0, 2));
            end
            pos = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, CELLS - 1))
                                               : POS_W'($urandom_range(CELLS, 63));
            send_request(req, pos, CODE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pin_model.pending_pins.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_commands(logic [CODE_W-1:0] line1, logic [CODE_W-1:0] line2);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_LINE1_CMD;
        i_cfg_wdata <= line1;
        pin_model.line1_cmd = line1;
        @(negedge i_clk);
        i_cfg_idx <= CFG_LINE2_CMD;
        i_cfg_wdata <= line2;
        pin_model.line2_cmd = line2;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        repeat (3) send_request(REQ_TICK, '0, '0);
        send_request(REQ_WRITE_CHAR, 6'd0, 8'hFF);
        send_request(REQ_WRITE_CHAR, 6'd31, 8'h00);
        send_request(REQ_WRITE_CHAR, 6'd32, 8'h55);
        send_request(REQ_WRITE_CHAR, 6'd63, 8'hAA);
        send_request(REQ_SET_BLINK, 6'd0, 8'h00);
        send_request(REQ_SET_BLINK, 6'd31, 8'hFF);
        send_request(REQ_SET_BLINK, 6'd32, 8'h00);
        send_request(REQ_SET_BLINK, 6'd63, 8'hFF);
        send_request(REQ_CLR_BLINK, 6'd31, 8'h00);
        send_request(REQ_CLR_BLINK, 6'd40, 8'h00);
        send_request(REQ_CLR_ALL, 6'd63, 8'hFF);
        send_request(REQ_SET_BLINK, 6'd0, 8'h00);
        for (int k = 0; k < 3; k++) begin
            send_request(REQ_W'(REQ_FIRST_UNUSED + k), 6'd63, 8'hFF);
        end
        repeat (6) send_request(REQ_TICK, 6'd63, 8'hFF);

        wait_until_drained();
        write_commands(8'h00, 8'hFF);
        rx_long_hold = 1'b1;
        send_random_requests(550);

        wait_until_drained();
        write_commands(8'hFF, 8'h00);
        send_random_requests(550);

        wait_until_drained();
        write_commands(CODE_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)));
        send_random_requests(580);

        wait_until_drained();
        if (pin_model.pending_pins.size() != 0) begin
            pin_model.report_mismatch("results still expected at the end");
        end
        if (pin_model.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
